// ===== rtl/core/cpot_pkg.sv =====
package cpot_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int SQ_BITS    = 2 * DIFF_BITS;
   localparam int SUM_BITS   = SQ_BITS + 1;
   localparam int BIG_BITS   = 2 * SUM_BITS + 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [SQ_BITS-1:0]    sq_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;
   typedef logic signed [BIG_BITS-1:0]   big_type;

   typedef enum logic [1:0] {
      SHAPE_BOX    = 2'd0,
      SHAPE_CIRCLE = 2'd1,
      SHAPE_SEG    = 2'd2,
      SHAPE_NONE   = 2'd3
   } shape_type;

   typedef enum logic [3:0] {
      PAIR_NONE = 4'd0,
      PAIR_BB   = 4'd1,
      PAIR_CC   = 4'd2,
      PAIR_BC   = 4'd3,
      PAIR_SS   = 4'd4,
      PAIR_SC   = 4'd5,
      PAIR_SB   = 4'd6
   } pair_type;

   typedef struct packed {
      logic [1:0] kind;
      coord_type  x0;
      coord_type  y0;
      coord_type  x1;
      coord_type  y1;
   } shape_in_type;

   typedef struct packed {
      shape_in_type a;
      shape_in_type b;
   } pair_in_type;

endpackage

// ===== rtl/core/cpot_if.sv =====
interface cpot_req_if;
   import cpot_pkg::*;
   logic        valid;
   logic        ready;
   pair_in_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cpot_rsp_if;
   logic valid;
   logic ready;
   logic overlap_hit;
   modport source (output valid, output overlap_hit, input ready);
   modport sink   (input valid, input overlap_hit, output ready);
endinterface

// ===== rtl/core/cpot_diff.sv =====
// stage 1: pair decode, operand ordering and coordinate differences
module cpot_diff (
   input  logic                 clock,
   input  logic                 en,
   input  cpot_pkg::pair_in_type pair,
   output cpot_pkg::pair_type   kind_ff,
   output cpot_pkg::diff_type   d_ff [16],
   output logic                 bb_ff
);
   import cpot_pkg::*;

   pair_type     kind_in;
   shape_in_type p, q;
   diff_type     d_in [16];
   coord_type    cx, cy;

   function automatic diff_type sub(coord_type a, coord_type b);
      return diff_type'(a) - diff_type'(b);
   endfunction

   function automatic coord_type clampc(coord_type v, coord_type lo, coord_type hi);
      coord_type m;
      m = (v > lo) ? v : lo;
      return (m < hi) ? m : hi;
   endfunction

   always_comb begin
      kind_in = PAIR_NONE;
      p = pair.a;
      q = pair.b;
      unique case ({pair.a.kind, pair.b.kind})
         {SHAPE_BOX, SHAPE_BOX}:       kind_in = PAIR_BB;
         {SHAPE_CIRCLE, SHAPE_CIRCLE}: kind_in = PAIR_CC;
         {SHAPE_BOX, SHAPE_CIRCLE}:    kind_in = PAIR_BC;
         {SHAPE_CIRCLE, SHAPE_BOX}:    begin kind_in = PAIR_BC; p = pair.b; q = pair.a; end
         {SHAPE_SEG, SHAPE_SEG}:       kind_in = PAIR_SS;
         {SHAPE_SEG, SHAPE_CIRCLE}:    kind_in = PAIR_SC;
         {SHAPE_CIRCLE, SHAPE_SEG}:    begin kind_in = PAIR_SC; p = pair.b; q = pair.a; end
         {SHAPE_SEG, SHAPE_BOX}:       kind_in = PAIR_SB;
         {SHAPE_BOX, SHAPE_SEG}:       begin kind_in = PAIR_SB; p = pair.b; q = pair.a; end
         default:                      kind_in = PAIR_NONE;
      endcase
      cx = clampc(q.x0, p.x0, p.x1);
      cy = clampc(q.y0, p.y0, p.y1);
      for (int i = 0; i < 16; i++) d_in[i] = '0;
      unique case (kind_in)
         PAIR_CC: begin
            d_in[0] = sub(p.x0, q.x0); d_in[1] = sub(p.y0, q.y0);
            d_in[2] = diff_type'(p.x1) + diff_type'(q.x1);
         end
         PAIR_BC: begin
            d_in[0] = sub(q.x0, cx); d_in[1] = sub(q.y0, cy);
            d_in[2] = diff_type'(q.x1);
         end
         PAIR_SC: begin
            // s = q-p, t = c-p, u = c-q
            d_in[0] = sub(p.x1, p.x0); d_in[1] = sub(p.y1, p.y0);
            d_in[2] = diff_type'(q.x1);
            d_in[3] = sub(q.x0, p.x0); d_in[4] = sub(q.y0, p.y0);
            d_in[5] = sub(q.x0, p.x1); d_in[6] = sub(q.y0, p.y1);
         end
         PAIR_SS: begin
            // edge ab with ac, ad; edge cd with ca, cb
            d_in[0] = sub(p.x1, p.x0); d_in[1] = sub(p.y1, p.y0);
            d_in[2] = sub(q.x0, p.x0); d_in[3] = sub(q.y0, p.y0);
            d_in[4] = sub(q.x1, p.x0); d_in[5] = sub(q.y1, p.y0);
            d_in[6] = sub(q.x1, q.x0); d_in[7] = sub(q.y1, q.y0);
            d_in[8] = sub(p.x0, q.x0); d_in[9] = sub(p.y0, q.y0);
            d_in[10] = sub(p.x1, q.x0); d_in[11] = sub(p.y1, q.y0);
         end
         PAIR_SB: begin
            // segment vs box corner points, and box edge vectors
            d_in[0] = sub(p.x1, p.x0); d_in[1] = sub(p.y1, p.y0);
            d_in[2] = sub(q.x0, p.x0); d_in[3] = sub(q.y0, p.y0);
            d_in[4] = sub(q.x1, p.x0); d_in[5] = sub(q.y1, p.y0);
            d_in[6] = sub(q.x1, q.x0); d_in[7] = sub(q.y1, q.y0);
            d_in[8] = sub(p.x0, q.x0); d_in[9] = sub(p.y0, q.y0);
            d_in[10] = sub(p.x1, q.x0); d_in[11] = sub(p.y1, q.y0);
            d_in[12] = sub(p.x0, q.x1); d_in[13] = sub(p.y0, q.y1);
            d_in[14] = sub(p.x1, q.x1); d_in[15] = sub(p.y1, q.y1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff <= kind_in;
         d_ff    <= d_in;
         bb_ff   <= pair.a.x0 < pair.b.x1 && pair.a.x1 > pair.b.x0 &&
                    pair.a.y0 < pair.b.y1 && pair.a.y1 > pair.b.y0;
      end
   end
endmodule

// ===== rtl/core/cpot_prod.sv =====
// stage 2: products, stage 3: sums and orientation signs
module cpot_prod (
   input  logic               clock,
   input  logic               en,
   input  cpot_pkg::pair_type kind,
   input  cpot_pkg::diff_type d [16],
   input  logic               bb,
   output cpot_pkg::pair_type kind_ff,
   output cpot_pkg::sum_type  s_ff [4],
   output logic               hit_ff
);
   import cpot_pkg::*;

   sq_type   m_ff [20];
   sq_type   m_in [20];
   pair_type k2_ff;
   logic     bb2_ff;
   sum_type  s_in [4];
   logic     hit_in;
   logic     o [8];

   function automatic sq_type mul(diff_type a, diff_type b);
      return sq_type'(a) * sq_type'(b);
   endfunction

   always_comb begin
      for (int i = 0; i < 20; i++) m_in[i] = '0;
      unique case (kind)
         PAIR_CC, PAIR_BC: begin
            m_in[0] = mul(d[0], d[0]); m_in[1] = mul(d[1], d[1]);
            m_in[2] = mul(d[2], d[2]);
         end
         PAIR_SC: begin
            m_in[0] = mul(d[0], d[0]); m_in[1] = mul(d[1], d[1]);
            m_in[2] = mul(d[2], d[2]);
            m_in[3] = mul(d[3], d[0]); m_in[4] = mul(d[4], d[1]);
            m_in[5] = mul(d[3], d[3]); m_in[6] = mul(d[4], d[4]);
            m_in[7] = mul(d[5], d[5]); m_in[8] = mul(d[6], d[6]);
            m_in[9] = mul(d[3], d[1]); m_in[10] = mul(d[4], d[0]);
         end
         PAIR_SS, PAIR_SB: begin
            // orient(a,b,c): (b.y-a.y)*(c.x-a.x) < (c.y-a.y)*(b.x-a.x)
            m_in[0] = mul(d[1], d[2]);  m_in[1] = mul(d[3], d[0]);
            m_in[2] = mul(d[1], d[4]);  m_in[3] = mul(d[5], d[0]);
            m_in[4] = mul(d[7], d[8]);  m_in[5] = mul(d[9], d[6]);
            m_in[6] = mul(d[7], d[10]); m_in[7] = mul(d[11], d[6]);
            // box corners bl=(x0,y0) br=(x1,y0) tr=(x1,y1) tl=(x0,y1)
            m_in[8]  = mul(d[1], d[4]); m_in[9]  = mul(d[3], d[0]);
            m_in[10] = mul(d[1], d[2]); m_in[11] = mul(d[5], d[0]);
            m_in[12] = mul(d[9], d[6]);  m_in[13] = mul(d[11], d[6]);
            m_in[14] = mul(d[13], d[6]); m_in[15] = mul(d[15], d[6]);
            m_in[16] = mul(d[8], d[7]);  m_in[17] = mul(d[10], d[7]);
            m_in[18] = mul(d[12], d[7]); m_in[19] = mul(d[14], d[7]);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff   <= m_in;
         k2_ff  <= kind;
         bb2_ff <= bb;
      end
   end

   function automatic sum_type ext(sq_type v);
      return sum_type'(v);
   endfunction

   always_comb begin
      for (int i = 0; i < 4; i++) s_in[i] = '0;
      for (int i = 0; i < 8; i++) o[i] = 1'b0;
      hit_in = 1'b0;
      unique case (k2_ff)
         PAIR_BB: hit_in = bb2_ff;
         PAIR_CC, PAIR_BC:
            hit_in = ext(m_ff[2]) >= ext(m_ff[0]) + ext(m_ff[1]);
         PAIR_SC: begin
            s_in[0] = ext(m_ff[0]) + ext(m_ff[1]);
            s_in[1] = ext(m_ff[3]) + ext(m_ff[4]);
            s_in[2] = ext(m_ff[9]) - ext(m_ff[10]);
            s_in[3] = ext(m_ff[2]);
            if (s_in[1] <= 0)
               hit_in = ext(m_ff[2]) >= ext(m_ff[5]) + ext(m_ff[6]);
            else if (s_in[1] >= s_in[0])
               hit_in = ext(m_ff[2]) >= ext(m_ff[7]) + ext(m_ff[8]);
         end
         PAIR_SS: begin
            o[0] = m_ff[0] < m_ff[1]; o[1] = m_ff[2] < m_ff[3];
            o[2] = m_ff[4] < m_ff[5]; o[3] = m_ff[6] < m_ff[7];
            hit_in = (o[0] != o[1]) && (o[2] != o[3]);
         end
         PAIR_SB: begin
            // orientation of segment ends vs each box corner line, and corners vs segment
            // corner c orient(p,q,c): sdy*(cx-px) < (cy-py)*sdx
            o[0] = m_ff[10] < m_ff[1];  // bl
            o[1] = m_ff[8] < m_ff[1];   // br (x1,y0)
            o[2] = m_ff[2] < m_ff[11];  // tr
            o[3] = m_ff[0] < m_ff[3];   // tl (x0,y1)
            // edge e from u to v, endpoint w: (v.y-u.y)*(w.x-u.x) < (w.y-u.y)*(v.x-u.x)
            // bottom edge bl->br: dy=0, dx=bw; o = 0 < (w.y-y0)*bw
            o[4] = (ext(m_ff[12]) > 0) != (ext(m_ff[13]) > 0);
            // right edge br->tr: dx=0, dy=bh; o = bh*(w.x-x1) < 0
            o[5] = (ext(m_ff[18]) < 0) != (ext(m_ff[19]) < 0);
            // top edge tr->tl: dy=0, dx=-bw; o = 0 < -(w.y-y1)*bw
            o[6] = (ext(m_ff[14]) < 0) != (ext(m_ff[15]) < 0);
            // left edge tl->bl: dx=0, dy=-bh; o = -bh*(w.x-x0) < 0
            o[7] = (ext(m_ff[16]) > 0) != (ext(m_ff[17]) > 0);
            hit_in = (o[4] && (o[0] != o[1])) || (o[5] && (o[1] != o[2])) ||
                     (o[6] && (o[2] != o[3])) || (o[7] && (o[3] != o[0]));
         end
         default: hit_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff    <= s_in;
         hit_ff  <= hit_in;
         kind_ff <= k2_ff;
      end
   end
endmodule

// ===== rtl/core/cpot_perp.sv =====
// stages 4 and 5: interior segment-circle test r^2 * |s|^2 >= cross^2
module cpot_perp (
   input  logic               clock,
   input  logic               en,
   input  cpot_pkg::pair_type kind,
   input  cpot_pkg::sum_type  s [4],
   input  logic               hit,
   output logic               hit_ff
);
   import cpot_pkg::*;

   big_type lhs_ff, rhs_ff;
   logic    mid_ff, hit4_ff;
   logic    mid_in;

   assign mid_in = kind == PAIR_SC && s[1] > 0 && s[1] < s[0];

   always_ff @(posedge clock) begin
      if (en) begin
         lhs_ff  <= big_type'(s[3]) * big_type'(s[0]);
         rhs_ff  <= big_type'(s[2]) * big_type'(s[2]);
         mid_ff  <= mid_in;
         hit4_ff <= hit;
         hit_ff  <= mid_ff ? (lhs_ff >= rhs_ff) : hit4_ff;
      end
   end
endmodule

// ===== rtl/core/collider_pair_overlap_test_unit.sv =====
// Shape-pair overlap test for boxes, circles and segments. One pair is accepted per
// cycle while rsp back-pressure does not stall the pipeline. The pipeline is five
// register stages (differences, products, sums and signs, wide product, compare);
// rsp back-pressure stalls the whole pipeline, and a request is taken whenever the
// final stage is empty or being drained.
module collider_pair_overlap_test_unit (
   input logic       clock,
   input logic       reset,
   cpot_req_if.sink   req,
   cpot_rsp_if.source rsp
);
   import cpot_pkg::*;

   localparam int STAGES = 5;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic              en;
   pair_type          k1, k3;
   diff_type          d1 [16];
   logic              bb1, h3;
   sum_type           s3 [4];

   assign en        = !vld_ff[STAGES-1] || rsp.ready;
   assign req.ready = en;
   assign vld_in    = {vld_ff[STAGES-2:0], req.valid};
   assign rsp.valid = vld_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   cpot_diff u_diff (
      .clock(clock), .en(en), .pair(req.data), .kind_ff(k1), .d_ff(d1), .bb_ff(bb1)
   );

   cpot_prod u_prod (
      .clock(clock), .en(en), .kind(k1), .d(d1), .bb(bb1),
      .kind_ff(k3), .s_ff(s3), .hit_ff(h3)
   );

   cpot_perp u_perp (
      .clock(clock), .en(en), .kind(k3), .s(s3), .hit(h3), .hit_ff(rsp.overlap_hit)
   );
endmodule
